// ----- hw/rtl/dlt_pkg.sv -----
package dlt_pkg;

    localparam int TOK_W         = 13;
    localparam int CFG_DATA_W    = 64;
    localparam int CFG_IDX_W     = 2;
    localparam int LEN_W         = 5;
    localparam int REG_BYTES     = 8;
    localparam int SEP_CFG_BYTES = 16;

    localparam logic [7:0]       SPACE_CHAR = 8'd32;
    localparam logic [TOK_W-1:0] COUNT_CAP  = 13'd4096;

    localparam logic [LEN_W-1:0]      LEN_RST      = 5'd1;
    localparam logic [CFG_DATA_W-1:0] BYTES_LO_RST = 64'd32;
    localparam logic [CFG_DATA_W-1:0] BYTES_HI_RST = 64'd0;
    localparam logic [TOK_W-1:0]      LIMIT_RST    = 13'd4096;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DELIM_LEN   = 2'd0,
        CFG_BYTES_LO    = 2'd1,
        CFG_BYTES_HI    = 2'd2,
        CFG_TOKEN_LIMIT = 2'd3
    } t_cfg_idx;

    typedef enum logic [1:0] {
        KIND_CHAR = 2'd0,
        KIND_END  = 2'd1,
        KIND_LIST = 2'd2
    } t_kind;

    // what follows the pending characters of one input word
    typedef struct packed {
        logic             tend;
        logic             tail;
        logic             lend;
        logic [7:0]       tchar;
        logic [TOK_W-1:0] c0;
        logic [TOK_W-1:0] c1;
    } t_ctl;

endpackage

// ----- hw/rtl/dlt_in_if.sv -----
interface dlt_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       end_of_list;

    modport source (output valid, output char_code, output end_of_list, input ready);
    modport sink (input valid, input char_code, input end_of_list, output ready);
endinterface

// ----- hw/rtl/dlt_out_if.sv -----
interface dlt_out_if;
    logic                     valid;
    logic                     ready;
    logic [7:0]               out_char;
    logic [1:0]               item_kind;
    logic [dlt_pkg::TOK_W-1:0] token_index;
    logic                     list_done;

    modport source (output valid, output out_char, output item_kind, output token_index,
                    output list_done, input ready);
    modport sink (input valid, input out_char, input item_kind, input token_index,
                  input list_done, output ready);
endinterface

// ----- hw/rtl/dlt_core.sv -----
module dlt_core #(
    parameter int MAX_DELIM = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [dlt_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [dlt_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    dlt_in_if.sink                              i_in,
    input  logic                                i_free,
    output logic                                o_load,
    output logic [MAX_DELIM:0][7:0]             o_bytes,
    output logic [$clog2(MAX_DELIM+2)-1:0]      o_nchar,
    output dlt_pkg::t_ctl                       o_ctl
);

    localparam int CW = $clog2(MAX_DELIM + 1);
    localparam int XW = $clog2(MAX_DELIM + 2);

    // input register
    logic       r_in_vld;
    logic [7:0] r_in_char;
    logic       r_in_eol;

    // configuration
    logic [dlt_pkg::LEN_W-1:0]      r_len;
    logic [dlt_pkg::CFG_DATA_W-1:0] r_lo;
    logic [dlt_pkg::CFG_DATA_W-1:0] r_hi;
    logic [dlt_pkg::TOK_W-1:0]      r_lim;

    // list state
    logic [MAX_DELIM-1:0][7:0]  r_win;
    logic [MAX_DELIM-1:0][7:0]  n_win;
    logic [CW-1:0]              r_cnt;
    logic [CW-1:0]              n_cnt;
    logic [dlt_pkg::TOK_W-1:0]  r_tok;
    logic [dlt_pkg::TOK_W-1:0]  n_tok;
    logic                       r_seen;
    logic                       n_seen;
    logic                       r_run;
    logic                       n_run;

    logic [MAX_DELIM:0][7:0]            x;
    logic [MAX_DELIM-1:0][7:0]          sep;
    logic [MAX_DELIM+1:0][MAX_DELIM-1:0] eqm;
    logic [MAX_DELIM+1:0]               pref;
    logic [XW-1:0]                      leff;
    logic [XW-1:0]                      n;
    logic [XW-1:0]                      s_min;
    logic [XW-1:0]                      s_hit;
    logic [XW-1:0]                      m;
    logic                               match;
    logic                               spc;
    logic                               c0_ok;
    logic                               tail_req;
    logic [dlt_pkg::TOK_W-1:0]          lim;

    assign o_load     = r_in_vld && i_free;
    assign i_in.ready = !r_in_vld || o_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_in.ready) begin
            r_in_vld <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_char <= i_in.char_code;
            r_in_eol  <= i_in.end_of_list;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= dlt_pkg::LEN_RST;
            r_lo  <= dlt_pkg::BYTES_LO_RST;
            r_hi  <= dlt_pkg::BYTES_HI_RST;
            r_lim <= dlt_pkg::LIMIT_RST;
        end else if (i_cfg_we) begin
            unique case (dlt_pkg::t_cfg_idx'(i_cfg_idx))
                dlt_pkg::CFG_DELIM_LEN:   r_len <= i_cfg_data[dlt_pkg::LEN_W-1:0];
                dlt_pkg::CFG_BYTES_LO:    r_lo  <= i_cfg_data;
                dlt_pkg::CFG_BYTES_HI:    r_hi  <= i_cfg_data;
                dlt_pkg::CFG_TOKEN_LIMIT: r_lim <= i_cfg_data[dlt_pkg::TOK_W-1:0];
            endcase
        end
    end

    // separator bytes past the configured sixteen read as zero
    for (genvar gi = 0; gi < MAX_DELIM; gi++) begin : g_sep
        if (gi < dlt_pkg::REG_BYTES) begin : g_lo
            assign sep[gi] = r_lo[8*gi +: 8];
        end else if (gi < dlt_pkg::SEP_CFG_BYTES) begin : g_hi
            assign sep[gi] = r_hi[8*(gi-dlt_pkg::REG_BYTES) +: 8];
        end else begin : g_zero
            assign sep[gi] = 8'h00;
        end
    end

    // pending window with the new character appended at position r_cnt
    always_comb begin
        for (int j = 0; j < MAX_DELIM; j++) begin
            x[j] = (CW'(j) == r_cnt) ? r_in_char : r_win[j];
        end
        x[MAX_DELIM] = r_in_char;
        n = XW'(r_cnt) + XW'(1);
        if (r_len == '0) begin
            leff = XW'(1);
        end else if (int'(r_len) > MAX_DELIM) begin
            leff = XW'(MAX_DELIM);
        end else begin
            leff = XW'(r_len);
        end
        lim = (r_lim > dlt_pkg::COUNT_CAP) ? dlt_pkg::COUNT_CAP : r_lim;
        spc = (leff == XW'(1)) && (sep[0] == dlt_pkg::SPACE_CHAR);
    end

    // byte compare of every window offset against every separator position
    for (genvar gs = 0; gs <= MAX_DELIM + 1; gs++) begin : g_off
        for (genvar gi = 0; gi < MAX_DELIM; gi++) begin : g_pos
            if (gs + gi <= MAX_DELIM) begin : g_cmp
                assign eqm[gs][gi] = (x[gs+gi] == sep[gi]);
            end else begin : g_none
                assign eqm[gs][gi] = 1'b1;
            end
        end
    end

    always_comb begin
        // pref[s]: bytes from offset s on could still start the separator
        for (int s = 0; s <= MAX_DELIM + 1; s++) begin
            pref[s] = (s <= int'(n)) && ((int'(n) - s) <= int'(leff));
            for (int i = 0; i < MAX_DELIM; i++) begin
                if (s + i < int'(n)) begin
                    pref[s] = pref[s] & eqm[s][i];
                end
            end
        end
        // a full window always gives up its oldest byte
        s_min = (r_cnt == CW'(MAX_DELIM)) ? XW'(1) : XW'(0);
        s_hit = XW'(MAX_DELIM + 1);
        for (int s = MAX_DELIM + 1; s >= 0; s--) begin
            if (pref[s] && (XW'(s) >= s_min)) begin
                s_hit = XW'(s);
            end
        end
        m     = n - s_hit;
        match = (m == leff);

        for (int j = 0; j < MAX_DELIM; j++) begin
            n_win[j] = 8'h00;
            for (int s = 0; s <= MAX_DELIM - j; s++) begin
                if (s_hit == XW'(s)) begin
                    n_win[j] = x[j+s];
                end
            end
        end

        c0_ok    = r_tok < lim;
        tail_req = 1'b0;
        o_bytes  = x;
        o_nchar  = '0;
        o_ctl    = '0;
        n_cnt    = r_cnt;
        n_seen   = r_seen;
        n_run    = r_run;

        priority if (r_in_eol) begin
            o_nchar   = c0_ok ? XW'(r_cnt) : '0;
            o_ctl.tend = c0_ok;
            o_ctl.lend = 1'b1;
            n_cnt     = '0;
            n_seen    = 1'b0;
            n_run     = 1'b0;
        end else if (spc) begin
            o_nchar = c0_ok ? XW'(r_cnt) : '0;
            n_cnt   = '0;
            if (r_in_char == dlt_pkg::SPACE_CHAR) begin
                if (r_seen) begin
                    n_run = 1'b1;
                end
            end else begin
                o_ctl.tend = r_run && c0_ok;
                tail_req   = 1'b1;
                n_run      = 1'b0;
                n_seen     = 1'b1;
            end
        end else begin
            o_nchar    = c0_ok ? s_hit : '0;
            o_ctl.tend = match && c0_ok;
            n_cnt      = match ? '0 : CW'(m);
            n_seen     = 1'b1;
            n_run      = 1'b0;
        end

        o_ctl.c0    = r_tok;
        o_ctl.c1    = r_tok + dlt_pkg::TOK_W'(o_ctl.tend);
        o_ctl.tail  = tail_req && (o_ctl.c1 < lim);
        o_ctl.tchar = r_in_char;
        n_tok       = r_in_eol ? '0 : o_ctl.c1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_tok  <= '0;
            r_seen <= 1'b0;
            r_run  <= 1'b0;
        end else if (o_load) begin
            r_cnt  <= n_cnt;
            r_tok  <= n_tok;
            r_seen <= n_seen;
            r_run  <= n_run;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_load) begin
            r_win <= n_win;
        end
    end

    a_eol_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_load && r_in_eol |=> (r_cnt == '0) && (r_tok == '0) && !r_seen && !r_run)
        else $error("list state not cleared after list end");

    a_space_no_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_load && !r_in_eol && spc |=> (r_cnt == '0))
        else $error("bytes left pending in space mode");

    a_string_seen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_load && !r_in_eol && !spc |=> r_seen && !r_run)
        else $error("string separator word did not mark content");

endmodule

// ----- hw/rtl/dlt_drain.sv -----
module dlt_drain #(
    parameter int MAX_DELIM = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_load,
    input  logic [MAX_DELIM:0][7:0]        i_bytes,
    input  logic [$clog2(MAX_DELIM+2)-1:0] i_nchar,
    input  dlt_pkg::t_ctl                  i_ctl,
    output logic                           o_free,
    dlt_out_if.source                      o_out
);

    localparam int XW = $clog2(MAX_DELIM + 2);

    logic [MAX_DELIM:0][7:0]   r_bytes;
    logic [XW-1:0]             r_nchar;
    logic                      r_tend;
    logic                      r_tail;
    logic                      r_lend;
    logic [7:0]                r_tchar;
    logic [dlt_pkg::TOK_W-1:0] r_c0;
    logic [dlt_pkg::TOK_W-1:0] r_c1;
    logic [XW:0]               rem;
    logic                      fire;
    dlt_pkg::t_kind            kind;

    assign rem = {1'b0, r_nchar} + (XW+1)'(r_tend) + (XW+1)'(r_tail) + (XW+1)'(r_lend);

    assign o_out.valid = (rem != '0);
    assign fire        = o_out.valid && o_out.ready;
    // free when empty or when the last word goes out this cycle
    assign o_free      = (rem == '0) || ((rem == (XW+1)'(1)) && o_out.ready);

    always_comb begin
        priority if (r_nchar != '0) begin
            o_out.out_char    = r_bytes[0];
            kind              = dlt_pkg::KIND_CHAR;
            o_out.token_index = r_c0;
            o_out.list_done   = 1'b0;
        end else if (r_tend) begin
            o_out.out_char    = 8'h00;
            kind              = dlt_pkg::KIND_END;
            o_out.token_index = r_c0;
            o_out.list_done   = 1'b0;
        end else if (r_tail) begin
            o_out.out_char    = r_tchar;
            kind              = dlt_pkg::KIND_CHAR;
            o_out.token_index = r_c1;
            o_out.list_done   = 1'b0;
        end else begin
            o_out.out_char    = 8'h00;
            kind              = dlt_pkg::KIND_LIST;
            o_out.token_index = r_c1;
            o_out.list_done   = r_lend;
        end
        o_out.item_kind = kind;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nchar <= '0;
            r_tend  <= 1'b0;
            r_tail  <= 1'b0;
            r_lend  <= 1'b0;
        end else if (i_load) begin
            r_nchar <= i_nchar;
            r_tend  <= i_ctl.tend;
            r_tail  <= i_ctl.tail;
            r_lend  <= i_ctl.lend;
        end else if (fire) begin
            priority if (r_nchar != '0) begin
                r_nchar <= r_nchar - XW'(1);
            end else if (r_tend) begin
                r_tend <= 1'b0;
            end else if (r_tail) begin
                r_tail <= 1'b0;
            end else begin
                r_lend <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_bytes <= i_bytes;
            r_tchar <= i_ctl.tchar;
            r_c0    <= i_ctl.c0;
            r_c1    <= i_ctl.c1;
        end else if (fire && (r_nchar != '0)) begin
            r_bytes <= r_bytes >> 8;
        end
    end

    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> o_free)
        else $error("descriptor loaded over pending words");

    a_done_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.list_done |-> (rem == (XW+1)'(1)))
        else $error("list end is not the last word");

    a_index_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.list_done |-> (o_out.token_index < dlt_pkg::COUNT_CAP))
        else $error("token index past cap");

endmodule

// ----- hw/rtl/delimited_list_tokenizer.sv -----
// Delimited list tokenizer.
// i_in carries one list character per word (char_code), or a word with
// end_of_list set that closes the list. o_out carries token characters
// (item_kind 0), token ends (1) and one list end (2, list_done set, token
// count in token_index). Separator and token limit are written through
// i_cfg_we / i_cfg_idx / i_cfg_data; the user must do so only while no
// list word is in flight, which the block itself does not enforce. An input
// word passes the input register, then the output descriptor register,
// before its first output word is valid.
// Throughput: one input word per cycle while each input word yields at
// most one output word and o_out.ready is high. An input word that yields
// k output words keeps the descriptor register busy until all k are taken;
// the next input word waits in the input register, and ready drops once
// that register is occupied. The window compare for a string separator
// covers all offsets combinationally; the output port drains one word per
// cycle while o_out.ready is high. Reset: separator is a single space,
// limit 4096, list state empty; the block is ready for words on release.
// When o_out.ready is low the current output word holds, at most one more
// input word is absorbed, then i_in.ready goes low.
module delimited_list_tokenizer #(
    parameter int MAX_DELIM = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [dlt_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [dlt_pkg::CFG_DATA_W-1:0] i_cfg_data,
    dlt_in_if.sink                         i_in,
    dlt_out_if.source                      o_out
);

    localparam int XW = $clog2(MAX_DELIM + 2);

    logic                    w_load;
    logic                    w_free;
    logic [MAX_DELIM:0][7:0] w_bytes;
    logic [XW-1:0]           w_nchar;
    dlt_pkg::t_ctl           w_ctl;

    dlt_core #(
        .MAX_DELIM (MAX_DELIM)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (i_in),
        .i_free     (w_free),
        .o_load     (w_load),
        .o_bytes    (w_bytes),
        .o_nchar    (w_nchar),
        .o_ctl      (w_ctl)
    );

    dlt_drain #(
        .MAX_DELIM (MAX_DELIM)
    ) u_drain (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_load),
        .i_bytes (w_bytes),
        .i_nchar (w_nchar),
        .i_ctl   (w_ctl),
        .o_free  (w_free),
        .o_out   (o_out)
    );

endmodule
